// ----- design/hdoi_pkg.sv -----
// Shared types, constants and command codes for the hall-door open interlock.
// No dependencies; every other design file imports this package.
`default_nettype none

package hdoi_pkg;

  // Default floor count of the door bitmap.
  localparam int FLOORS_DEF = 32;
  // Widest bitmap the design supports, used for zero extension.
  localparam int MAP_EXT_W  = 64;

  localparam int FLOOR_NUM_W = 6;   // one-based floor numbers and scan bounds
  localparam int TIMER_W     = 16;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam int SAFETY_W    = 8;
  localparam int TOP_FLOOR_W = 5;
  localparam int CAR_FLOOR_W = 5;
  localparam int BITMAP_W    = 32;

  localparam int CMD_W       = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 56;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CMD_W-1:0] CMD_REPORT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALL_CLOSED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK      = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SAFETY_TIME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_FLOOR   = 2'd1;

  // Request from the sequencer to the scan unit.
  typedef struct packed {
    logic                   start;
    logic [FLOOR_NUM_W-1:0] last;
  } scan_req_t;

  // Result returned by the scan unit.
  typedef struct packed {
    logic                   done;
    logic [1:0]             count;
    logic [FLOOR_NUM_W-1:0] first;
    logic [FLOOR_NUM_W-1:0] second;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- design/hall_door_open_interlock_top.sv -----
// Hall-door open interlock: keeps the door bitmap, the open-time counter and the fault latch,
// and on a periodic check runs a floor-by-floor scan for open doors. A door report, an
// all-closed command, an unused command, or a check that is bypassed or meets a latched fault
// passes through the execute and emit states. A check that scans passes through the execute,
// scan, evaluate and emit states; its scan covers the bitmap up to index min(top_floor,
// FLOORS-1) in the scan unit, which tests one floor per cycle and stops early at the second
// open door. The emit state waits while the output is stalled. One item is worked on at a
// time; the next item is taken as soon as the result sits in the output register.
// Depends on hdoi_pkg and hdoi_scan.
`default_nettype none

module hall_door_open_interlock_top #(
  parameter int FLOORS = hdoi_pkg::FLOORS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // floor[6:0], door_closed[7], auto_mode[8], car_door_closed[9], car_floor[14:10], tick[15]
  input  wire logic [hdoi_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // command[1:0]
  input  wire logic [hdoi_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // run_off[0], car_error[1], fault[2], open_count[4:3], first_open_floor[10:5],
  // second_open_floor[16:11], door_bitmap[48:17], zero fill[55:49]
  output logic [hdoi_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [hdoi_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [hdoi_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hdoi_pkg::*;

  localparam int IDX_W = $clog2(FLOORS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;

  // Configuration registers.
  logic [SAFETY_W-1:0]    safety_time;
  logic [TOP_FLOOR_W-1:0] top_floor;

  // Latched input item.
  logic [CMD_W-1:0]       command;
  logic [6:0]             floor;
  logic                   door_closed;
  logic                   auto_mode;
  logic                   car_door_closed;
  logic [CAR_FLOOR_W-1:0] car_floor;
  logic                   tick;

  // Interlock state.
  logic [FLOORS-1:0]      door_map;
  logic [TIMER_W-1:0]     open_timer;
  logic                   fault_latch;
  logic                   run_off_flag;
  logic                   car_error;
  logic [1:0]             open_count;
  logic [FLOOR_NUM_W-1:0] first_open;
  logic [FLOOR_NUM_W-1:0] second_open;

  logic [5:0]             folded;
  logic [TIMER_W-1:0]     timer_inc;
  logic [TIMER_W-1:0]     timer_kept;
  logic [FLOOR_NUM_W-1:0] scan_last;
  logic [MAP_EXT_W-1:0]   map_ext;
  logic                   accept;

  scan_req_t scan_req;
  scan_res_t scan_res;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // Folding by 64 drops the top bit of the seven-bit floor number.
  assign folded    = floor[5:0];
  assign timer_inc = (tick && open_timer != TIMER_MAX) ? open_timer + TIMER_W'(1) : open_timer;
  assign timer_kept = car_door_closed ? open_timer : '0;
  assign scan_last = (FLOOR_NUM_W'(top_floor) > FLOOR_NUM_W'(FLOORS - 1))
                     ? FLOOR_NUM_W'(FLOORS - 1) : FLOOR_NUM_W'(top_floor);
  assign map_ext   = MAP_EXT_W'(door_map);

  assign scan_req.start = (state == S_EXEC) && (command == CMD_CHECK) && (safety_time != '0)
                          && !auto_mode && !fault_latch;
  assign scan_req.last  = scan_last;

  hdoi_scan #(.FLOORS(FLOORS)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .door_map (door_map),
    .req      (scan_req),
    .res      (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      safety_time <= '0;
      top_floor   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAFETY_TIME: safety_time <= cfg_data[SAFETY_W-1:0];
        REG_TOP_FLOOR:   top_floor   <= cfg_data[TOP_FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      command         <= s_axis_tuser;
      floor           <= s_axis_tdata[6:0];
      door_closed     <= s_axis_tdata[7];
      auto_mode       <= s_axis_tdata[8];
      car_door_closed <= s_axis_tdata[9];
      car_floor       <= s_axis_tdata[14:10];
      tick            <= s_axis_tdata[15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      door_map      <= '1;
      open_timer    <= '0;
      fault_latch   <= 1'b0;
      run_off_flag  <= 1'b0;
      car_error     <= 1'b0;
      open_count    <= 2'd0;
      first_open    <= '0;
      second_open   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // In the emit state the output handshake is handled by the emit arm alone.
      if (m_axis_tvalid && m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            car_error  <= 1'b0;
            open_count <= 2'd0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_EMIT;
          case (command)
            CMD_REPORT: begin
              if (7'(folded) < 7'(FLOORS)) begin
                door_map[folded[IDX_W-1:0]] <= door_closed;
              end
            end
            CMD_ALL_CLOSED: door_map <= '1;
            CMD_CHECK: begin
              if (safety_time == '0 || auto_mode) begin
                if (fault_latch) begin
                  run_off_flag <= 1'b0;
                end
                open_timer  <= '0;
                fault_latch <= 1'b0;
              end else if (fault_latch) begin
                run_off_flag <= 1'b1;
                car_error    <= 1'b1;
                open_timer   <= '0;
              end else begin
                open_timer <= timer_inc;
                state      <= S_SCAN;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (scan_res.done) begin
            open_count  <= scan_res.count;
            first_open  <= scan_res.first;
            second_open <= scan_res.second;
            state       <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_EMIT;
          if (open_count == 2'd2) begin
            fault_latch <= 1'b1;
            open_timer  <= '0;
          end else if (open_count == 2'd1) begin
            if (first_open == FLOOR_NUM_W'(car_floor) + FLOOR_NUM_W'(1)) begin
              open_timer <= '0;
            end else begin
              // The counter only runs while the car door is closed.
              open_timer <= timer_kept;
              if (timer_kept > TIMER_W'(safety_time)) begin
                fault_latch <= 1'b1;
              end
            end
          end else begin
            open_timer <= '0;
          end
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {7'd0, map_ext[BITMAP_W-1:0], second_open, first_open, open_count,
                       fault_latch, car_error, run_off_flag};
    end
  end

endmodule

`default_nettype wire

// ----- design/hdoi_scan.sv -----
// Iterative open-door scan: tests one floor of the door bitmap per clock cycle.
// Depends on hdoi_pkg for the request and result structures.
`default_nettype none

module hdoi_scan #(
  parameter int FLOORS = hdoi_pkg::FLOORS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [FLOORS-1:0]  door_map,
  input  wire hdoi_pkg::scan_req_t req,
  output hdoi_pkg::scan_res_t     res
);
  import hdoi_pkg::*;

  localparam int IDX_W = $clog2(FLOORS);

  logic                   busy;
  logic                   done;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       last;
  logic [1:0]             count;
  logic [FLOOR_NUM_W-1:0] first;
  logic [FLOOR_NUM_W-1:0] second;
  logic                   is_open;
  logic [FLOOR_NUM_W-1:0] floor_num;

  assign is_open   = !door_map[idx];
  assign floor_num = FLOOR_NUM_W'(idx) + FLOOR_NUM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        idx    <= '0;
        last   <= req.last[IDX_W-1:0];
        count  <= 2'd0;
        first  <= '0;
        second <= '0;
      end else if (busy) begin
        if (is_open) begin
          if (count == 2'd0) begin
            first <= floor_num;
          end else begin
            second <= floor_num;
          end
          count <= count + 2'd1;
        end
        // The scan ends at the bound or as soon as a second open door turns up.
        if (idx == last || (is_open && count == 2'd1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  assign res.done   = done;
  assign res.count  = count;
  assign res.first  = first;
  assign res.second = second;

endmodule

`default_nettype wire

// ----- design/hdoi_checker.sv -----
// Port-level checker for the hall-door open interlock, bound to the top level.
// Depends on hdoi_pkg for port widths; sees the top-level ports only.
`default_nettype none

module hdoi_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [hdoi_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import hdoi_pkg::*;

  // Only one transaction is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is still in work");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output payload changed while stalled");

  // A car error only comes with run-off and a latched fault.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[0] && m_axis_tdata[2]))
    else $error("car error without run-off and fault");

  // Two open doors found by a scan latch the fault at once.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4:3] == 2'd2) |-> m_axis_tdata[2])
    else $error("two open doors without a fault");

  // A single open door leaves a first floor and no second floor.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4:3] == 2'd1)
      |-> (m_axis_tdata[10:5] != 6'd0 && m_axis_tdata[16:11] == 6'd0))
    else $error("single open door with inconsistent floor record");

endmodule

bind hall_door_open_interlock_top hdoi_checker u_hdoi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- bench/hall_door_open_interlock_top_tb.sv -----
// Testbench for hall_door_open_interlock_top: directed door, command and interlock cases,
// then phases of random traffic, each checked against a behavioural model of the interlock.
// Depends on hdoi_pkg and the design files under design/.
`default_nettype none

module hall_door_open_interlock_top_tb;
  import hdoi_pkg::*;

  localparam int FLOORS = FLOORS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PHASE_ITEMS = 200;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [6:0]             floor;
    logic                   door_closed;
    logic                   auto_mode;
    logic                   car_door_closed;
    logic [CAR_FLOOR_W-1:0] car_floor;
    logic                   tick;
  } door_event_t;

  typedef struct packed {
    logic                   run_off;
    logic                   car_error;
    logic                   fault;
    logic [1:0]             open_count;
    logic [FLOOR_NUM_W-1:0] first_open;
    logic [FLOOR_NUM_W-1:0] second_open;
    logic [BITMAP_W-1:0]    door_bitmap;
  } interlock_status_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Model state of the interlock and its registers.
  logic [SAFETY_W-1:0]    safety_time;
  logic [TOP_FLOOR_W-1:0] top_floor;
  logic [FLOORS-1:0]      door_map;
  logic [TIMER_W-1:0]     open_timer;
  logic                   fault_latch;
  logic                   run_off_flag;
  logic [FLOOR_NUM_W-1:0] open_floors [2];

  interlock_status_t status_queue [$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  int  stall_left = 0;

  hall_door_open_interlock_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic door_event_t door_event(logic [CMD_W-1:0] cmd, logic [6:0] fl,
                                             bit closed, bit aut, bit car_closed,
                                             logic [CAR_FLOOR_W-1:0] car_fl, bit tk);
    door_event_t ev;
    ev.command         = cmd;
    ev.floor           = fl;
    ev.door_closed     = closed;
    ev.auto_mode       = aut;
    ev.car_door_closed = car_closed;
    ev.car_floor       = car_fl;
    ev.tick            = tk;
    return ev;
  endfunction

  task automatic reset_model();
    safety_time    = '0;
    top_floor      = 5'd31;
    door_map       = '1;
    open_timer     = '0;
    fault_latch    = 1'b0;
    run_off_flag   = 1'b0;
    open_floors[0] = '0;
    open_floors[1] = '0;
  endtask

  // Applies one door event to the model and returns the status the block should report.
  task automatic predict_status(input door_event_t ev, output interlock_status_t st);
    logic [6:0] fl;
    int count;
    int last;
    int f;
    logic car_err;
    count   = 0;
    car_err = 1'b0;
    case (ev.command)
      CMD_REPORT: begin
        fl = ev.floor;
        if (fl >= 64) fl = fl - 7'd64;
        if (fl < FLOORS) door_map[fl] = ev.door_closed;
      end
      CMD_ALL_CLOSED: door_map = '1;
      CMD_CHECK: begin
        if (ev.tick && open_timer != TIMER_MAX) open_timer = open_timer + 1'b1;
        if (safety_time == 0 || ev.auto_mode) begin
          if (fault_latch) run_off_flag = 1'b0;
          open_timer  = '0;
          fault_latch = 1'b0;
        end else if (fault_latch) begin
          run_off_flag = 1'b1;
          car_err      = 1'b1;
          open_timer   = '0;
        end else begin
          last = (top_floor > FLOORS - 1) ? FLOORS - 1 : top_floor;
          for (f = 0; f <= last && count < 2; f++) begin
            if (!door_map[f]) begin
              open_floors[count] = FLOOR_NUM_W'(f + 1);
              count++;
            end
          end
          if (count == 2) begin
            fault_latch = 1'b1;
            open_timer  = '0;
          end else if (count == 1) begin
            open_floors[1] = '0;
            if (open_floors[0] == ev.car_floor + 6'd1) begin
              open_timer = '0;
            end else begin
              if (!ev.car_door_closed) open_timer = '0;
              if (open_timer > safety_time) fault_latch = 1'b1;
            end
          end else begin
            open_floors[0] = '0;
            open_floors[1] = '0;
            open_timer     = '0;
          end
        end
      end
      default: ;
    endcase
    st.run_off     = run_off_flag;
    st.car_error   = car_err;
    st.fault       = fault_latch;
    st.open_count  = 2'(count);
    st.first_open  = open_floors[0];
    st.second_open = open_floors[1];
    st.door_bitmap = BITMAP_W'(door_map);
  endtask

  // Sends one event, optionally after an idle burst, and records its expected status.
  task automatic send_event(input door_event_t ev);
    interlock_status_t st;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tdata  <= {ev.tick, ev.car_floor, ev.car_door_closed, ev.auto_mode,
                      ev.door_closed, ev.floor};
    s_axis_tuser  <= ev.command;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_status(ev, st);
    status_queue.push_back(st);
  endtask

  // Holds off new events until every outstanding status has been returned.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (status_queue.size() != 0);
  endtask

  // Writes both registers back to back; only called while the block is idle.
  task automatic write_config(input logic [SAFETY_W-1:0] st_val,
                              input logic [TOP_FLOOR_W-1:0] top_val);
    cfg_index <= REG_SAFETY_TIME;
    cfg_data  <= st_val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    safety_time = st_val;
    cfg_index <= REG_TOP_FLOOR;
    cfg_data  <= CFG_DATA_W'(top_val);
    do @(posedge clk); while (!cfg_ready);
    top_floor = top_val;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  function automatic door_event_t random_event();
    door_event_t ev;
    int r;
    int low_open;
    low_open = -1;
    for (int f = FLOORS - 1; f >= 0; f--)
      if (!door_map[f]) low_open = f;
    r = $urandom_range(0, 99);
    ev.command = (r < 45) ? CMD_REPORT : (r < 55) ? CMD_ALL_CLOSED :
                 (r < 97) ? CMD_CHECK : CMD_UNUSED;
    // Mostly floors that land in the bitmap, with or without the fold.
    if ($urandom_range(0, 4) == 0)
      ev.floor = 7'($urandom_range(0, 127));
    else
      ev.floor = 7'($urandom_range(0, 31) + ($urandom_range(0, 1) ? 64 : 0));
    ev.door_closed     = ($urandom_range(0, 9) < 7);
    ev.auto_mode       = ($urandom_range(0, 11) == 0);
    ev.car_door_closed = ($urandom_range(0, 6) != 0);
    if (low_open >= 0 && $urandom_range(0, 2) == 0)
      ev.car_floor = CAR_FLOOR_W'(low_open);
    else
      ev.car_floor = CAR_FLOOR_W'($urandom_range(0, 31));
    ev.tick = ($urandom_range(0, 3) != 0);
    return ev;
  endfunction

  task automatic test_door_reports();
    send_event(door_event(CMD_REPORT, 7'd0,   0, 0, 1, 5'd0,  0));
    send_event(door_event(CMD_REPORT, 7'd31,  0, 1, 0, 5'd31, 1));
    send_event(door_event(CMD_REPORT, 7'd127, 0, 0, 1, 5'd0,  0));
    send_event(door_event(CMD_REPORT, 7'd95,  1, 0, 1, 5'd0,  0));
    send_event(door_event(CMD_REPORT, 7'd64,  1, 0, 1, 5'd0,  0));
    send_event(door_event(CMD_REPORT, 7'd32,  0, 0, 1, 5'd0,  0));
  endtask

  task automatic test_all_closed_and_unused();
    send_event(door_event(CMD_REPORT,     7'd5, 0, 0, 1, 5'd0, 0));
    send_event(door_event(CMD_UNUSED,     7'd5, 1, 1, 1, 5'd7, 1));
    send_event(door_event(CMD_ALL_CLOSED, 7'd0, 0, 0, 1, 5'd0, 0));
  endtask

  task automatic test_interlock_cases();
    drain_results();
    write_config(8'd2, 5'd31);
    // Two open doors: the fault latches now, run-off follows at the next check.
    send_event(door_event(CMD_REPORT, 7'd3, 0, 0, 1, 5'd0, 0));
    send_event(door_event(CMD_REPORT, 7'd9, 0, 0, 1, 5'd0, 0));
    send_event(door_event(CMD_CHECK,  7'd0, 0, 0, 1, 5'd0, 1));
    send_event(door_event(CMD_CHECK,  7'd0, 0, 0, 1, 5'd0, 1));
    send_event(door_event(CMD_CHECK,  7'd0, 0, 1, 1, 5'd0, 1));
    send_event(door_event(CMD_ALL_CLOSED, 7'd0, 0, 0, 1, 5'd0, 0));
    // One open door: away from the car's floor, with the car door open, then timing out.
    send_event(door_event(CMD_REPORT, 7'd7, 0, 0, 1, 5'd0, 0));
    send_event(door_event(CMD_CHECK,  7'd0, 0, 0, 1, 5'd6, 1));
    send_event(door_event(CMD_CHECK,  7'd0, 0, 0, 0, 5'd0, 1));
    repeat (3) send_event(door_event(CMD_CHECK, 7'd0, 0, 0, 1, 5'd0, 1));
    send_event(door_event(CMD_CHECK,  7'd0, 0, 0, 1, 5'd0, 0));
    // A zero safety time switches the interlock off and clears the fault.
    drain_results();
    write_config(8'd0, 5'd0);
    send_event(door_event(CMD_CHECK,  7'd0, 0, 0, 1, 5'd0, 0));
  endtask

  task automatic test_random_traffic(input logic [SAFETY_W-1:0] st_val,
                                     input logic [TOP_FLOOR_W-1:0] top_val);
    drain_results();
    write_config(st_val, top_val);
    repeat (RANDOM_PHASE_ITEMS) send_event(random_event());
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_door_reports();
    test_all_closed_and_unused();
    test_interlock_cases();
    test_random_traffic(8'd0,   5'd31);
    test_random_traffic(8'd255, 5'd31);
    test_random_traffic(8'd4,   5'd0);
    test_random_traffic(8'($urandom_range(1, 12)), 5'($urandom_range(0, 31)));
    test_random_traffic(8'($urandom_range(1, 6)),  5'($urandom_range(8, 31)));
    test_random_traffic(8'($urandom_range(1, 255)), 5'($urandom_range(0, 31)));
    no_idle = 1'b1;
    test_random_traffic(8'($urandom_range(1, 8)),  5'd31);
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("hall_door_open_interlock_top test passed");
    end else begin
      $display("hall_door_open_interlock_top test failed");
    end
    $finish;
  end

  // Result sink with random back-pressure bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    interlock_status_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (status_queue.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata, 0);
      end else begin
        want = status_queue.pop_front();
        if (m_axis_tdata[0] !== want.run_off)
          report_mismatch("run_off", m_axis_tdata[0], want.run_off);
        if (m_axis_tdata[1] !== want.car_error)
          report_mismatch("car_error", m_axis_tdata[1], want.car_error);
        if (m_axis_tdata[2] !== want.fault)
          report_mismatch("fault", m_axis_tdata[2], want.fault);
        if (m_axis_tdata[4:3] !== want.open_count)
          report_mismatch("open_count", m_axis_tdata[4:3], want.open_count);
        if (m_axis_tdata[10:5] !== want.first_open)
          report_mismatch("first_open_floor", m_axis_tdata[10:5], want.first_open);
        if (m_axis_tdata[16:11] !== want.second_open)
          report_mismatch("second_open_floor", m_axis_tdata[16:11], want.second_open);
        if (m_axis_tdata[48:17] !== want.door_bitmap)
          report_mismatch("door_bitmap", m_axis_tdata[48:17], want.door_bitmap);
        if (m_axis_tdata[55:49] !== '0)
          report_mismatch("zero fill", m_axis_tdata[55:49], 0);
      end
    end
  end

  // Ends the run if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("hall_door_open_interlock_top test failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hall_door_open_interlock_top.f -----
design/hdoi_pkg.sv
design/hdoi_scan.sv
design/hall_door_open_interlock_top.sv
design/hdoi_checker.sv
bench/hall_door_open_interlock_top_tb.sv
